@@ design/wsp_pkg.sv @@
package wsp_pkg;

    // result status codes
    localparam logic [2:0] ST_PCM          = 3'd0;
    localparam logic [2:0] ST_COMPLETE     = 3'd1;
    localparam logic [2:0] ST_NOT_RIFF     = 3'd2;
    localparam logic [2:0] ST_BAD_FORMAT   = 3'd3;
    localparam logic [2:0] ST_DATA_NO_FMT  = 3'd4;
    localparam logic [2:0] ST_DATA_ALIGN   = 3'd5;
    localparam logic [2:0] ST_INCOMPLETE   = 3'd6;
    localparam logic [2:0] ST_RAW_ALIGN    = 3'd7;

    // input item kinds
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_EOS  = 1'b1;

    // chunk tags, little-endian byte order
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [31:0] FMT_BODY_LEN = 32'd16;

    typedef enum logic [3:0] {
        PH_HEADER    = 4'd0,
        PH_CHUNK_HDR = 4'd1,
        PH_FMT       = 4'd2,
        PH_FMT_SKIP  = 4'd3,
        PH_SKIP      = 4'd4,
        PH_PAD       = 4'd5,
        PH_DATA      = 4'd6,
        PH_DONE_PEND = 4'd7,
        PH_HALT      = 4'd8
    } phase_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] pcm_byte;
    } result_t;

    typedef struct packed {
        logic       check;
        logic [7:0] value;
    } fmt_rule_t;

    // expected fmt body: pcm, 2 channels, 48000 Hz, byte rate unchecked, align 4, 16 bits
    function automatic fmt_rule_t fmt_rule(input logic [3:0] idx);
        fmt_rule_t r;
        r.check = 1'b1;
        r.value = 8'h00;
        case (idx)
            4'd0:    r.value = 8'h01;
            4'd2:    r.value = 8'h02;
            4'd4:    r.value = 8'h80;
            4'd5:    r.value = 8'hBB;
            4'd8,
            4'd9,
            4'd10,
            4'd11:   r.check = 1'b0;
            4'd12:   r.value = 8'h04;
            4'd14:   r.value = 8'h10;
            default: r.value = 8'h00;
        endcase
        return r;
    endfunction

endpackage

@@ design/wav_stream_parser.sv @@
// Streaming parser for RIFF/WAVE PCM files, one byte per transaction.
// Input channel: in_valid / in_stall with kind (0 file byte, 1 end of stream)
// and data_byte. Output channel: out_valid / out_stall with status and
// pcm_byte; each input item gives zero or one result.
// Config channel: cfg_valid / cfg_ready with raw_mode; cfg_ready is always
// high, and a write also rearms the parser. Write it only while idle.
// A result passes the input register, then the result register, before it
// is presented; a stalled output can hold it between the two.
// Throughput: one item per cycle while the output is not stalled, set by the
// combinational parse step between the two registers.
// A stalled output holds its result; the input register keeps taking the
// next item while the result register still waits, and stalls the input
// side only when both are full.
// Reset clears the handshake registers, selects header mode and puts the
// parser back to expecting the RIFF tag. After a final status given for a
// byte, bytes are ignored until an end-of-stream item rearms the parser.
module wav_stream_parser (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       kind,
    input  logic [7:0] data_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] status,
    output logic [7:0] pcm_byte,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       raw_mode
);

    wsp_pkg::item_t   in_item;
    wsp_pkg::item_t   item;
    wsp_pkg::result_t res;
    wsp_pkg::result_t out_res;
    logic             item_valid;
    logic             res_valid;
    logic             load_ok;
    logic             advance;

    assign cfg_ready         = 1'b1;
    assign in_item.kind      = kind;
    assign in_item.data_byte = data_byte;
    assign advance           = item_valid && load_ok;
    assign status            = out_res.status;
    assign pcm_byte          = out_res.pcm_byte;

    wsp_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    wsp_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_valid && cfg_ready),
        .cfg_raw_mode (raw_mode),
        .item         (item),
        .advance      (advance),
        .res_valid    (res_valid),
        .res          (res)
    );

    wsp_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .res_valid (res_valid),
        .res       (res),
        .load_ok   (load_ok),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res)
    );

    // input side stalls only behind a full, stalled result register
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled while result register free");

    // an accepted transaction lands in the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> item_valid)
        else $error("accepted item lost");

    // a taken result with nothing behind it leaves the output empty
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !item_valid) |=> !out_valid)
        else $error("result repeated");

    // only sample results carry a byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != wsp_pkg::ST_PCM) |-> (pcm_byte == 8'h00))
        else $error("status result carries a byte");

endmodule

@@ design/wsp_in_reg.sv @@
module wsp_in_reg (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  wsp_pkg::item_t in_item,
    input  logic           advance,
    output logic           item_valid,
    output wsp_pkg::item_t item
);

    logic           valid_reg;
    wsp_pkg::item_t item_reg;

    // hold the item while the stage ahead cannot take it
    assign in_stall   = valid_reg && !advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            valid_reg <= in_valid;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            item_reg <= in_item;
        end
    end

endmodule

@@ design/wsp_parser.sv @@
module wsp_parser (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write,
    input  logic             cfg_raw_mode,
    input  wsp_pkg::item_t   item,
    input  logic             advance,
    output logic             res_valid,
    output wsp_pkg::result_t res
);

    logic             raw_mode_reg;
    wsp_pkg::phase_t  phase_reg,       phase_next;
    logic [31:0]      chunk_tag_reg,   chunk_tag_next;
    logic [31:0]      chunk_length_reg, chunk_length_next;
    logic [31:0]      bytes_left_reg,  bytes_left_next;
    logic [3:0]       field_shift_reg, field_shift_next;
    logic             format_seen_reg, format_seen_next;
    logic             format_bad_reg,  format_bad_next;
    logic [1:0]       frame_phase_reg, frame_phase_next;

    logic [31:0]       tag_shift;
    logic [31:0]       len_shift;
    logic [31:0]       bytes_dec;
    logic [31:0]       fmt_extra;
    logic              bad_eff;
    wsp_pkg::fmt_rule_t rule;

    // state registers; a config write rearms everything
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_mode_reg     <= 1'b0;
            phase_reg        <= wsp_pkg::PH_HEADER;
            chunk_tag_reg    <= '0;
            chunk_length_reg <= '0;
            bytes_left_reg   <= '0;
            field_shift_reg  <= '0;
            format_seen_reg  <= 1'b0;
            format_bad_reg   <= 1'b0;
            frame_phase_reg  <= '0;
        end
        else if (cfg_write)
        begin
            raw_mode_reg     <= cfg_raw_mode;
            phase_reg        <= wsp_pkg::PH_HEADER;
            chunk_tag_reg    <= '0;
            chunk_length_reg <= '0;
            bytes_left_reg   <= '0;
            field_shift_reg  <= '0;
            format_seen_reg  <= 1'b0;
            format_bad_reg   <= 1'b0;
            frame_phase_reg  <= '0;
        end
        else if (advance)
        begin
            phase_reg        <= phase_next;
            chunk_tag_reg    <= chunk_tag_next;
            chunk_length_reg <= chunk_length_next;
            bytes_left_reg   <= bytes_left_next;
            field_shift_reg  <= field_shift_next;
            format_seen_reg  <= format_seen_next;
            format_bad_reg   <= format_bad_next;
            frame_phase_reg  <= frame_phase_next;
        end
    end

    // shared datapath pieces
    assign tag_shift = {item.data_byte, chunk_tag_reg[31:8]};
    assign len_shift = {item.data_byte, chunk_length_reg[31:8]};
    assign bytes_dec = bytes_left_reg - 32'd1;
    assign fmt_extra = chunk_length_reg - wsp_pkg::FMT_BODY_LEN;
    assign rule      = wsp_pkg::fmt_rule(field_shift_reg);

    // next state and result
    always_comb
    begin
        phase_next        = phase_reg;
        chunk_tag_next    = chunk_tag_reg;
        chunk_length_next = chunk_length_reg;
        bytes_left_next   = bytes_left_reg;
        field_shift_next  = field_shift_reg;
        format_seen_next  = format_seen_reg;
        format_bad_next   = format_bad_reg;
        frame_phase_next  = frame_phase_reg;
        res_valid         = 1'b0;
        res.status        = wsp_pkg::ST_PCM;
        res.pcm_byte      = 8'h00;
        bad_eff           = format_bad_reg;

        if (raw_mode_reg)
        begin
            if (item.kind == wsp_pkg::KIND_EOS)
            begin
                res_valid         = 1'b1;
                res.status        = (frame_phase_reg != 2'd0) ? wsp_pkg::ST_RAW_ALIGN
                                                              : wsp_pkg::ST_COMPLETE;
                phase_next        = wsp_pkg::PH_HEADER;
                chunk_tag_next    = '0;
                chunk_length_next = '0;
                bytes_left_next   = '0;
                field_shift_next  = '0;
                format_seen_next  = 1'b0;
                format_bad_next   = 1'b0;
                frame_phase_next  = '0;
            end
            else
            begin
                frame_phase_next = frame_phase_reg + 2'd1;
                res_valid        = 1'b1;
                res.pcm_byte     = item.data_byte;
            end
        end
        else if (item.kind == wsp_pkg::KIND_EOS)
        begin
            // end of stream: report unless already halted, then rearm
            if (phase_reg != wsp_pkg::PH_HALT)
            begin
                res_valid = 1'b1;
                case (phase_reg)
                    wsp_pkg::PH_HEADER:    res.status = wsp_pkg::ST_NOT_RIFF;
                    wsp_pkg::PH_DONE_PEND: res.status = wsp_pkg::ST_COMPLETE;
                    default:               res.status = wsp_pkg::ST_INCOMPLETE;
                endcase
            end
            phase_next        = wsp_pkg::PH_HEADER;
            chunk_tag_next    = '0;
            chunk_length_next = '0;
            bytes_left_next   = '0;
            field_shift_next  = '0;
            format_seen_next  = 1'b0;
            format_bad_next   = 1'b0;
            frame_phase_next  = '0;
        end
        else
        begin
            case (phase_reg)
                // riff size wave header, 12 bytes
                wsp_pkg::PH_HEADER:
                begin
                    chunk_tag_next   = tag_shift;
                    bad_eff          = format_bad_reg
                                     || (field_shift_reg == 4'd3 && tag_shift != wsp_pkg::TAG_RIFF)
                                     || (field_shift_reg == 4'd11 && tag_shift != wsp_pkg::TAG_WAVE);
                    format_bad_next  = bad_eff;
                    field_shift_next = field_shift_reg + 4'd1;
                    if (field_shift_reg == 4'd11)
                    begin
                        if (bad_eff)
                        begin
                            phase_next = wsp_pkg::PH_HALT;
                            res_valid  = 1'b1;
                            res.status = wsp_pkg::ST_NOT_RIFF;
                        end
                        else
                        begin
                            field_shift_next = '0;
                            phase_next       = wsp_pkg::PH_CHUNK_HDR;
                        end
                    end
                end

                // chunk tag and length, then dispatch on the tag
                wsp_pkg::PH_CHUNK_HDR:
                begin
                    if (field_shift_reg < 4'd4)
                    begin
                        chunk_tag_next = tag_shift;
                    end
                    else
                    begin
                        chunk_length_next = len_shift;
                    end
                    field_shift_next = field_shift_reg + 4'd1;
                    if (field_shift_reg == 4'd7)
                    begin
                        field_shift_next = '0;
                        if (chunk_tag_reg == wsp_pkg::TAG_FMT)
                        begin
                            if (len_shift[31:4] == 28'd0)
                            begin
                                phase_next = wsp_pkg::PH_HALT;
                                res_valid  = 1'b1;
                                res.status = wsp_pkg::ST_INCOMPLETE;
                            end
                            else
                            begin
                                format_bad_next = 1'b0;
                                phase_next      = wsp_pkg::PH_FMT;
                            end
                        end
                        else if (chunk_tag_reg == wsp_pkg::TAG_DATA)
                        begin
                            if (!format_seen_reg)
                            begin
                                phase_next = wsp_pkg::PH_HALT;
                                res_valid  = 1'b1;
                                res.status = wsp_pkg::ST_DATA_NO_FMT;
                            end
                            else if (len_shift[1:0] != 2'd0)
                            begin
                                phase_next = wsp_pkg::PH_HALT;
                                res_valid  = 1'b1;
                                res.status = wsp_pkg::ST_DATA_ALIGN;
                            end
                            else if (len_shift == 32'd0)
                            begin
                                phase_next = wsp_pkg::PH_HALT;
                                res_valid  = 1'b1;
                                res.status = wsp_pkg::ST_COMPLETE;
                            end
                            else
                            begin
                                bytes_left_next = len_shift;
                                phase_next      = wsp_pkg::PH_DATA;
                            end
                        end
                        else
                        begin
                            bytes_left_next = len_shift;
                            if (len_shift == 32'd0)
                            begin
                                phase_next = wsp_pkg::PH_CHUNK_HDR;
                            end
                            else
                            begin
                                phase_next = wsp_pkg::PH_SKIP;
                            end
                        end
                    end
                end

                // first 16 bytes of the fmt chunk
                wsp_pkg::PH_FMT:
                begin
                    bad_eff          = format_bad_reg
                                     || (rule.check && item.data_byte != rule.value);
                    format_bad_next  = bad_eff;
                    field_shift_next = field_shift_reg + 4'd1;
                    if (field_shift_reg == 4'd15)
                    begin
                        field_shift_next = '0;
                        bytes_left_next  = fmt_extra;
                        phase_next       = wsp_pkg::PH_FMT_SKIP;
                        if (fmt_extra == 32'd0)
                        begin
                            if (bad_eff)
                            begin
                                phase_next = wsp_pkg::PH_HALT;
                                res_valid  = 1'b1;
                                res.status = wsp_pkg::ST_BAD_FORMAT;
                            end
                            else
                            begin
                                format_seen_next = 1'b1;
                                phase_next       = chunk_length_reg[0] ? wsp_pkg::PH_PAD
                                                                       : wsp_pkg::PH_CHUNK_HDR;
                            end
                        end
                    end
                end

                // extra fmt bytes
                wsp_pkg::PH_FMT_SKIP:
                begin
                    bytes_left_next = bytes_dec;
                    if (bytes_dec == 32'd0)
                    begin
                        if (format_bad_reg)
                        begin
                            phase_next = wsp_pkg::PH_HALT;
                            res_valid  = 1'b1;
                            res.status = wsp_pkg::ST_BAD_FORMAT;
                        end
                        else
                        begin
                            format_seen_next = 1'b1;
                            field_shift_next = '0;
                            phase_next       = chunk_length_reg[0] ? wsp_pkg::PH_PAD
                                                                   : wsp_pkg::PH_CHUNK_HDR;
                        end
                    end
                end

                // unknown chunk body
                wsp_pkg::PH_SKIP:
                begin
                    bytes_left_next = bytes_dec;
                    if (bytes_dec == 32'd0)
                    begin
                        field_shift_next = '0;
                        phase_next       = chunk_length_reg[0] ? wsp_pkg::PH_PAD
                                                               : wsp_pkg::PH_CHUNK_HDR;
                    end
                end

                wsp_pkg::PH_PAD:
                begin
                    field_shift_next = '0;
                    phase_next       = wsp_pkg::PH_CHUNK_HDR;
                end

                // sample bytes pass out
                wsp_pkg::PH_DATA:
                begin
                    bytes_left_next = bytes_dec;
                    if (bytes_dec == 32'd0)
                    begin
                        phase_next = wsp_pkg::PH_DONE_PEND;
                    end
                    res_valid    = 1'b1;
                    res.pcm_byte = item.data_byte;
                end

                wsp_pkg::PH_DONE_PEND:
                begin
                    phase_next = wsp_pkg::PH_HALT;
                    res_valid  = 1'b1;
                    res.status = wsp_pkg::ST_COMPLETE;
                end

                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

endmodule

@@ design/wsp_out_reg.sv @@
module wsp_out_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic             res_valid,
    input  wsp_pkg::result_t res,
    output logic             load_ok,
    output logic             out_valid,
    input  logic             out_stall,
    output wsp_pkg::result_t out_res
);

    logic             valid_reg;
    wsp_pkg::result_t res_reg;

    // register is free when empty or its transaction completes now
    assign load_ok   = !valid_reg || !out_stall;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load_ok)
        begin
            valid_reg <= advance && res_valid;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (load_ok && advance && res_valid)
        begin
            res_reg <= res;
        end
    end

endmodule
